// ===== rtl/core/nidc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nidc_pkg
// Types, codes and constants shared by the identity number checker modules.
// ----------------------------------------------------------------------------
package nidc_pkg;

    localparam int MAX_REGIONS = 64;
    localparam int REG_CW      = $clog2(MAX_REGIONS + 1);
    localparam int REG_AW      = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

    localparam int OP_W     = 2;
    localparam int CODE_W   = 20;
    localparam int CHAR_W   = 8;
    localparam int VERD_W   = 2;
    localparam int YEAR_W   = 14;
    localparam int MD_W     = 7;
    localparam int RES_W    = 4;
    localparam int DIGIT_W  = 4;
    localparam int POS_W    = 5;
    localparam int ALU_W    = 20;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OPC_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OPC_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OPC_CHAR  = 2'd2;

    localparam logic [VERD_W-1:0] VERD_INVALID = 2'd0;
    localparam logic [VERD_W-1:0] VERD_MALE    = 2'd1;
    localparam logic [VERD_W-1:0] VERD_FEMALE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_YEAR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_YEAR = 1'b1;

    localparam logic [YEAR_W-1:0] MIN_YEAR_RESET = 14'd1900;
    localparam logic [YEAR_W-1:0] MAX_YEAR_RESET = 14'd2011;

    // Character positions, counted from zero.
    localparam logic [POS_W-1:0] POS_YEAR   = 5'd6;
    localparam logic [POS_W-1:0] POS_YEAR_LO = 5'd8;
    localparam logic [POS_W-1:0] POS_MONTH  = 5'd10;
    localparam logic [POS_W-1:0] POS_DAY    = 5'd12;
    localparam logic [POS_W-1:0] POS_SEQ    = 5'd14;
    localparam logic [POS_W-1:0] POS_GENDER = 5'd16;
    localparam logic [POS_W-1:0] POS_LAST   = 5'd17;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_X    = 8'h58;

    localparam logic [RES_W-1:0]   CHECK_MOD = 4'd11;
    localparam logic [RES_W-1:0]   CHECK_OK  = 4'd1;
    localparam logic [DIGIT_W-1:0] DIGIT_X   = 4'd10;

    localparam logic [MD_W-1:0] MONTH_FIRST = 7'd1;
    localparam logic [MD_W-1:0] MONTH_LAST  = 7'd12;
    localparam logic [MD_W-1:0] DAY_FIRST   = 7'd1;

    typedef enum logic [1:0] {
        ALU_MAC10,
        ALU_ADDMOD11,
        ALU_EQ,
        ALU_LE
    } t_alu_op;

    typedef struct packed {
        t_alu_op            op;
        logic [ALU_W-1:0]   a;
        logic [ALU_W-1:0]   b;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0]   y;
        logic               flag;
    } t_alu_rsp;

    typedef struct packed {
        logic               en;
        logic [REG_AW-1:0]  addr;
        logic [CODE_W-1:0]  data;
    } t_tbl_wr;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_RADD,
        S_RDBL,
        S_DATE,
        S_YMIN,
        S_YMAX,
        S_RD,
        S_CMP,
        S_DONE
    } t_state;

    function automatic logic [MD_W-1:0] month_days(input logic [MD_W-1:0] month,
                                                   input logic leap);
        logic [MD_W-1:0] days;
        unique case (month)
            7'd2: begin
                days = leap ? 7'd29 : 7'd28;
            end
            7'd4, 7'd6, 7'd9, 7'd11: begin
                days = 7'd30;
            end
            default: begin
                days = 7'd31;
            end
        endcase
        return days;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/nidc_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nidc_alu
// Shared arithmetic unit: decimal accumulate, add modulo eleven and compares.
// ----------------------------------------------------------------------------
module nidc_alu
    import nidc_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [ALU_W:0] sum;
    logic [ALU_W:0] modulus;

    assign modulus = (ALU_W + 1)'(CHECK_MOD);

    always_comb begin
        sum        = {1'b0, i_req.a} + {1'b0, i_req.b};
        o_rsp.y    = '0;
        o_rsp.flag = 1'b0;
        unique case (i_req.op)
            ALU_MAC10: begin
                // a * 10 as two shifts, then the new digit.
                o_rsp.y = (i_req.a << 3) + (i_req.a << 1) + i_req.b;
            end
            ALU_ADDMOD11: begin
                // Both operands are below eleven, so one subtraction suffices.
                if (sum >= modulus) begin
                    o_rsp.y = ALU_W'(sum - modulus);
                end else begin
                    o_rsp.y = sum[ALU_W-1:0];
                end
            end
            ALU_EQ: begin
                o_rsp.flag = (i_req.a == i_req.b);
            end
            ALU_LE: begin
                o_rsp.flag = (i_req.a <= i_req.b);
            end
            default: begin
                o_rsp.y = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/nidc_region_tbl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nidc_region_tbl
// Region code table: one write port and one registered read port.
// ----------------------------------------------------------------------------
module nidc_region_tbl
    import nidc_pkg::*;
(
    input  logic              i_clk,
    input  t_tbl_wr           i_wr,
    input  logic [REG_AW-1:0] i_rd_addr,
    output logic [CODE_W-1:0] o_rd_data
);

    logic [CODE_W-1:0] r_mem [MAX_REGIONS];
    logic [CODE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ===== rtl/core/national_id_number_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// national_id_number_checker
// Checks 18-character identity numbers against a loadable region table.
// ----------------------------------------------------------------------------
// Clear and add-region transactions are taken in the idle state. Characters one
// to seventeen pass through the states ACC, RADD and RDBL: the shared unit first
// accumulates the digit into its field, if it has one, then updates the MOD 11-2
// residue in two steps. The eighteenth character passes through RADD, DATE, YMIN
// and YMAX, then reads region table entries up to and including the match (at
// most the number of loaded codes, and none when an earlier check has already
// failed); the table walk reads one entry in RD and compares it in CMP through
// the single memory read port. The verdict then waits in an output register,
// and the block takes the next transaction while it is pending, stalling only
// if a second verdict is finished before the first has been taken.
// ----------------------------------------------------------------------------
module national_id_number_checker
    import nidc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration: index 0 min_year, index 1 max_year.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [YEAR_W-1:0]     i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: region_code [19:0], id_char [27:20], zero [31:28].
    input  logic [IN_W-1:0]       s_axis_tdata,
    // tuser: opcode [1:0].
    input  logic [OP_W-1:0]       s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: verdict [1:0], zero [7:2].
    output logic [OUT_W-1:0]      m_axis_tdata
);

    t_state r_state, n_state;

    logic [POS_W-1:0]   r_pos, n_pos;
    logic [CODE_W-1:0]  r_region, n_region;
    logic [YEAR_W-1:0]  r_year, n_year;
    logic [MD_W-1:0]    r_month, n_month;
    logic [MD_W-1:0]    r_day, n_day;
    logic [RES_W-1:0]   r_res, n_res;
    logic               r_seq_nz, n_seq_nz;
    logic               r_failed, n_failed;
    logic               r_gender, n_gender;
    logic [1:0]         r_yhi_m4, n_yhi_m4;
    logic [1:0]         r_ylo_m4, n_ylo_m4;
    logic               r_ylo_nz, n_ylo_nz;
    logic [REG_CW-1:0]  r_count, n_count;
    logic [YEAR_W-1:0]  r_min_year, n_min_year;
    logic [YEAR_W-1:0]  r_max_year, n_max_year;
    logic               r_out_valid, n_out_valid;
    logic [DIGIT_W-1:0] r_d, n_d;
    logic [REG_CW-1:0]  r_idx, n_idx;
    logic               r_ok, n_ok;
    logic [VERD_W-1:0]  r_verdict, n_verdict;

    logic [OP_W-1:0]    in_op;
    logic [CODE_W-1:0]  in_code;
    logic [CHAR_W-1:0]  in_char;
    logic [CHAR_W-1:0]  char_off;
    logic               in_digit;
    logic               in_x;
    logic               in_bad;
    logic [DIGIT_W-1:0] in_d;
    logic               accept;
    logic               last_pos;
    logic               leap;
    logic               out_free;
    logic [REG_CW-1:0]  idx_next;

    t_alu_req           alu_req;
    t_alu_rsp           alu_rsp;
    t_tbl_wr            tbl_wr;
    logic [CODE_W-1:0]  tbl_rd_data;

    nidc_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    nidc_region_tbl u_tbl (
        .i_clk     (i_clk),
        .i_wr      (tbl_wr),
        .i_rd_addr (r_idx[REG_AW-1:0]),
        .o_rd_data (tbl_rd_data)
    );

    assign in_op    = s_axis_tuser;
    assign in_code  = s_axis_tdata[CODE_W-1:0];
    assign in_char  = s_axis_tdata[CODE_W+CHAR_W-1:CODE_W];
    assign char_off = in_char - CHAR_ZERO;
    assign last_pos = (r_pos == POS_LAST);
    assign in_digit = (in_char >= CHAR_ZERO) && (in_char <= CHAR_NINE);
    // Only the final position takes an upper-case X, standing for ten.
    assign in_x     = last_pos && (in_char == CHAR_X);
    assign in_bad   = !in_digit && !in_x;
    assign in_d     = in_digit ? char_off[DIGIT_W-1:0] : (in_x ? DIGIT_X : '0);

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign idx_next      = r_idx + REG_CW'(1);

    // A year is a leap year when its last two digits are a nonzero multiple of
    // four, or are zero and the century digits are a multiple of four.
    assign leap = (r_ylo_nz && (r_ylo_m4 == 2'd0)) || (!r_ylo_nz && (r_yhi_m4 == 2'd0));

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_verdict);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (in_op == OPC_CHAR)) begin
                    n_state = last_pos ? S_RADD : S_ACC;
                end
            end
            S_ACC: begin
                n_state = S_RADD;
            end
            S_RADD: begin
                n_state = last_pos ? S_DATE : S_RDBL;
            end
            S_RDBL: begin
                n_state = S_IDLE;
            end
            S_DATE: begin
                n_state = S_YMIN;
            end
            S_YMIN: begin
                n_state = S_YMAX;
            end
            S_YMAX: begin
                if (r_ok && alu_rsp.flag && (r_count != '0)) begin
                    n_state = S_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (alu_rsp.flag || (idx_next == r_count)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath control and shared unit operands.
    always_comb begin
        n_pos       = r_pos;
        n_region    = r_region;
        n_year      = r_year;
        n_month     = r_month;
        n_day       = r_day;
        n_res       = r_res;
        n_seq_nz    = r_seq_nz;
        n_failed    = r_failed;
        n_gender    = r_gender;
        n_yhi_m4    = r_yhi_m4;
        n_ylo_m4    = r_ylo_m4;
        n_ylo_nz    = r_ylo_nz;
        n_count     = r_count;
        n_min_year  = r_min_year;
        n_max_year  = r_max_year;
        n_out_valid = r_out_valid;
        n_d         = r_d;
        n_idx       = r_idx;
        n_ok        = r_ok;
        n_verdict   = r_verdict;
        alu_req     = '{op: ALU_MAC10, a: '0, b: '0};
        tbl_wr      = '{en: 1'b0, addr: r_count[REG_AW-1:0], data: in_code};

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_YEAR: n_min_year = i_cfg_data;
                CFG_MAX_YEAR: n_max_year = i_cfg_data;
                default:      n_min_year = r_min_year;
            endcase
        end

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (in_op)
                        OPC_CLEAR: begin
                            n_count = '0;
                        end
                        OPC_ADD: begin
                            if (r_count < REG_CW'(MAX_REGIONS)) begin
                                tbl_wr.en = 1'b1;
                                n_count   = r_count + REG_CW'(1);
                            end
                        end
                        OPC_CHAR: begin
                            n_d = in_d;
                            if (in_bad) begin
                                n_failed = 1'b1;
                            end
                            if ((r_pos >= POS_SEQ) && !last_pos && (in_d != '0)) begin
                                n_seq_nz = 1'b1;
                            end
                            if (r_pos == POS_GENDER) begin
                                n_gender = in_d[0];
                            end
                            // Year digits modulo four, split at the century.
                            if ((r_pos >= POS_YEAR) && (r_pos < POS_YEAR_LO)) begin
                                n_yhi_m4 = {r_yhi_m4[0], 1'b0} + in_d[1:0];
                            end
                            if ((r_pos >= POS_YEAR_LO) && (r_pos < POS_MONTH)) begin
                                n_ylo_m4 = {r_ylo_m4[0], 1'b0} + in_d[1:0];
                                if (in_d != '0) begin
                                    n_ylo_nz = 1'b1;
                                end
                            end
                        end
                        default: begin
                            n_count = r_count;
                        end
                    endcase
                end
            end
            S_ACC: begin
                alu_req.op = ALU_MAC10;
                alu_req.b  = ALU_W'(r_d);
                if (r_pos < POS_YEAR) begin
                    alu_req.a = ALU_W'(r_region);
                    n_region  = alu_rsp.y[CODE_W-1:0];
                end else if (r_pos < POS_MONTH) begin
                    alu_req.a = ALU_W'(r_year);
                    n_year    = alu_rsp.y[YEAR_W-1:0];
                end else if (r_pos < POS_DAY) begin
                    alu_req.a = ALU_W'(r_month);
                    n_month   = alu_rsp.y[MD_W-1:0];
                end else if (r_pos < POS_SEQ) begin
                    alu_req.a = ALU_W'(r_day);
                    n_day     = alu_rsp.y[MD_W-1:0];
                end
            end
            S_RADD: begin
                alu_req.op = ALU_ADDMOD11;
                alu_req.a  = ALU_W'(r_res);
                alu_req.b  = ALU_W'(r_d);
                n_res      = alu_rsp.y[RES_W-1:0];
            end
            S_RDBL: begin
                // Doubling modulo eleven is the residue added to itself.
                alu_req.op = ALU_ADDMOD11;
                alu_req.a  = ALU_W'(r_res);
                alu_req.b  = ALU_W'(r_res);
                n_res      = alu_rsp.y[RES_W-1:0];
                n_pos      = r_pos + POS_W'(1);
            end
            S_DATE: begin
                n_idx = '0;
                n_ok  = !r_failed && (r_res == CHECK_OK) && r_seq_nz
                        && (r_month >= MONTH_FIRST) && (r_month <= MONTH_LAST)
                        && (r_day >= DAY_FIRST) && (r_day <= month_days(r_month, leap));
            end
            S_YMIN: begin
                alu_req.op = ALU_LE;
                alu_req.a  = ALU_W'(r_min_year);
                alu_req.b  = ALU_W'(r_year);
                n_ok       = r_ok && alu_rsp.flag;
            end
            S_YMAX: begin
                alu_req.op = ALU_LE;
                alu_req.a  = ALU_W'(r_year);
                alu_req.b  = ALU_W'(r_max_year);
                n_ok       = r_ok && alu_rsp.flag && (r_count != '0);
            end
            S_RD: begin
                n_idx = r_idx;
            end
            S_CMP: begin
                alu_req.op = ALU_EQ;
                alu_req.a  = ALU_W'(r_region);
                alu_req.b  = ALU_W'(tbl_rd_data);
                if (!alu_rsp.flag) begin
                    n_idx = idx_next;
                    if (idx_next == r_count) begin
                        n_ok = 1'b0;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_verdict   = r_ok ? (r_gender ? VERD_MALE : VERD_FEMALE) : VERD_INVALID;
                    n_pos       = '0;
                    n_region    = '0;
                    n_year      = '0;
                    n_month     = '0;
                    n_day       = '0;
                    n_res       = '0;
                    n_seq_nz    = 1'b0;
                    n_failed    = 1'b0;
                    n_gender    = 1'b0;
                    n_yhi_m4    = '0;
                    n_ylo_m4    = '0;
                    n_ylo_nz    = 1'b0;
                end
            end
            default: begin
                n_ok = r_ok;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_region    <= '0;
            r_year      <= '0;
            r_month     <= '0;
            r_day       <= '0;
            r_res       <= '0;
            r_seq_nz    <= 1'b0;
            r_failed    <= 1'b0;
            r_gender    <= 1'b0;
            r_yhi_m4    <= '0;
            r_ylo_m4    <= '0;
            r_ylo_nz    <= 1'b0;
            r_count     <= '0;
            r_min_year  <= MIN_YEAR_RESET;
            r_max_year  <= MAX_YEAR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_region    <= n_region;
            r_year      <= n_year;
            r_month     <= n_month;
            r_day       <= n_day;
            r_res       <= n_res;
            r_seq_nz    <= n_seq_nz;
            r_failed    <= n_failed;
            r_gender    <= n_gender;
            r_yhi_m4    <= n_yhi_m4;
            r_ylo_m4    <= n_ylo_m4;
            r_ylo_nz    <= n_ylo_nz;
            r_count     <= n_count;
            r_min_year  <= n_min_year;
            r_max_year  <= n_max_year;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d       <= n_d;
        r_idx     <= n_idx;
        r_ok      <= n_ok;
        r_verdict <= n_verdict;
    end

endmodule
`default_nettype wire

// ===== sim/national_id_number_checker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// national_id_number_checker_tb
// Self-checking bench for the identity number checker. Region tables are
// loaded and 18-character numbers are streamed in, mostly well formed with
// random content and the rest broken or mixed with noise. An in-bench
// predictor works out each verdict, and the bench compares it with what the
// block returns. Both stream sides idle at random, and the year bounds are
// rewritten between phases while the block is quiet.
// ----------------------------------------------------------------------------
module national_id_number_checker_tb;
    import nidc_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 11;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int STIM_ITEMS    = 1250;
    localparam int MIN_VERDICTS  = 48;
    localparam int PHASE_ITEMS   = 180;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_CYCLES  = 200;
    localparam int ID_CHARS      = 18;

    localparam logic [OP_W-1:0]   OPC_UNUSED   = 2'd3;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_X = 8'h78;

    typedef enum int {
        FLAW_NONE,
        FLAW_CHECK,
        FLAW_BYTE,
        FLAW_LOWER_X,
        FLAW_INTERLEAVE
    } flaw_t;

    // Predicts verdicts from the accepted transactions and checks returned ones.
    class VerdictBook;
        logic [CODE_W-1:0] regions [MAX_REGIONS];
        int unsigned       n_regions   = 0;
        logic [POS_W-1:0]  char_pos    = '0;
        logic [CODE_W-1:0] region_acc  = '0;
        logic [YEAR_W-1:0] year_acc    = '0;
        logic [MD_W-1:0]   month_acc   = '0;
        logic [MD_W-1:0]   day_acc     = '0;
        logic [RES_W-1:0]  residue     = '0;
        bit                seq_nonzero = 1'b0;
        bit                bad_char    = 1'b0;
        bit                odd_digit   = 1'b0;
        logic [YEAR_W-1:0] year_lo     = MIN_YEAR_RESET;
        logic [YEAR_W-1:0] year_hi     = MAX_YEAR_RESET;
        logic [VERD_W-1:0] due_verdicts [$];
        int                errors      = 0;
        int                verdicts    = 0;

        static function int unsigned month_length(input int unsigned month,
                                                  input int unsigned year);
            bit leap;
            leap = (year % 4 == 0 && year % 100 != 0) || year % 400 == 0;
            case (month)
                2: begin
                    return leap ? 29 : 28;
                end
                4, 6, 9, 11: begin
                    return 30;
                end
                default: begin
                    return 31;
                end
            endcase
        endfunction

        function void report(input string msg);
            $display("%0t ns: mismatch: %s", $realtime, msg);
            errors++;
        endfunction

        function void set_bound(input logic [CFG_IDX_W-1:0] idx,
                                input logic [YEAR_W-1:0] val);
            if (idx == CFG_MIN_YEAR) begin
                year_lo = val;
            end else begin
                year_hi = val;
            end
        endfunction

        function void restart_number();
            char_pos    = '0;
            region_acc  = '0;
            year_acc    = '0;
            month_acc   = '0;
            day_acc     = '0;
            residue     = '0;
            seq_nonzero = 1'b0;
            bad_char    = 1'b0;
            odd_digit   = 1'b0;
        endfunction

        function logic [VERD_W-1:0] judge();
            bit known;
            known = 1'b0;
            for (int i = 0; i < n_regions; i++) begin
                if (regions[i] == region_acc) known = 1'b1;
            end
            if (bad_char || !known || year_acc < year_lo || year_acc > year_hi)
                return VERD_INVALID;
            if (month_acc < 1 || month_acc > 12 || day_acc < 1 ||
                day_acc > month_length(month_acc, year_acc))
                return VERD_INVALID;
            if (!seq_nonzero || residue != CHECK_OK)
                return VERD_INVALID;
            return odd_digit ? VERD_MALE : VERD_FEMALE;
        endfunction

        function void take_char(input logic [CHAR_W-1:0] ch);
            bit          is_digit;
            int unsigned dv;
            is_digit = ch >= CHAR_ZERO && ch <= CHAR_NINE;
            dv = is_digit ? ch - CHAR_ZERO : 0;
            if (char_pos == POS_LAST) begin
                if (ch == CHAR_X) begin
                    dv = DIGIT_X;
                end else if (!is_digit) begin
                    bad_char = 1'b1;
                end
                residue = RES_W'((residue + dv) % CHECK_MOD);
                due_verdicts.push_back(judge());
                verdicts++;
                restart_number();
                return;
            end
            if (!is_digit) bad_char = 1'b1;
            if (char_pos < POS_YEAR) begin
                region_acc = CODE_W'(region_acc * 10 + dv);
            end else if (char_pos < POS_MONTH) begin
                year_acc = YEAR_W'(year_acc * 10 + dv);
            end else if (char_pos < POS_DAY) begin
                month_acc = MD_W'(month_acc * 10 + dv);
            end else if (char_pos < POS_SEQ) begin
                day_acc = MD_W'(day_acc * 10 + dv);
            end else begin
                if (dv != 0) seq_nonzero = 1'b1;
                if (char_pos == POS_GENDER) odd_digit = dv[0];
            end
            residue  = RES_W'(((residue + dv) * 2) % CHECK_MOD);
            char_pos = char_pos + 1'b1;
        endfunction

        function void take_input(input logic [OP_W-1:0] op, input logic [CODE_W-1:0] code,
                                 input logic [CHAR_W-1:0] ch);
            case (op)
                OPC_CLEAR: begin
                    n_regions = 0;
                end
                OPC_ADD: begin
                    // A full table drops the code without trace.
                    if (n_regions < MAX_REGIONS) begin
                        regions[n_regions] = code;
                        n_regions++;
                    end
                end
                OPC_CHAR: begin
                    take_char(ch);
                end
                default: begin
                end
            endcase
        endfunction

        function void match_verdict(input logic [VERD_W-1:0] got);
            logic [VERD_W-1:0] want;
            if (due_verdicts.size() == 0) begin
                report($sformatf("verdict %0d with none outstanding", got));
            end else begin
                want = due_verdicts.pop_front();
                if (got !== want)
                    report($sformatf("verdict %0d, predicted %0d", got, want));
            end
        endfunction
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [YEAR_W-1:0]    i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // tdata: region_code [19:0], id_char [27:20], zero [31:28].
    logic [IN_W-1:0]      s_axis_tdata  = '0;
    // tuser: opcode [1:0].
    logic [OP_W-1:0]      s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // tdata: verdict [1:0], zero [7:2].
    logic [OUT_W-1:0]     m_axis_tdata;

    VerdictBook  book = new;
    bit          steady = 1'b0;
    int unsigned cycles = 0;
    int unsigned items_sent = 0;
    int unsigned loaded_codes [$];
    int unsigned leap_probe [6] = '{1900, 2000, 2004, 2100, 2400, 1996};
    int unsigned bound_lo [6] = '{0, 9999, 2000, 0, 9999, 1900};
    int unsigned bound_hi [6] = '{9999, 0, 2000, 0, 9999, 2100};

    national_id_number_checker DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("national_id_number_checker_tb: done, errors");
            $finish;
        end
    end

    // Verdict side: ready may drop for a random stretch before a transaction.
    initial begin : verdict_sink
        int gap;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            gap = steady ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            book.match_verdict(m_axis_tdata[VERD_W-1:0]);
        end
    end

    // Every task below starts and ends just after a rising edge.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [CODE_W-1:0] code,
                             input logic [CHAR_W-1:0] ch);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_W - CODE_W - CHAR_W){1'b0}}, ch, code};
        do @(posedge i_clk); while (!s_axis_tready);
        book.take_input(op, code, ch);
        if (op != OPC_UNUSED) items_sent++;
    endtask

    task automatic stop_input();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits for the block to go quiet so that the bounds may be rewritten.
    task automatic settle();
        stop_input();
        while (book.due_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_bounds(input int unsigned lo, input int unsigned hi);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MIN_YEAR;
        i_cfg_data <= YEAR_W'(lo);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MAX_YEAR;
        i_cfg_data <= YEAR_W'(hi);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        book.set_bound(CFG_MIN_YEAR, YEAR_W'(lo));
        book.set_bound(CFG_MAX_YEAR, YEAR_W'(hi));
    endtask

    task automatic load_table(input int unsigned count);
        int unsigned code;
        send_item(OPC_CLEAR, CODE_W'($urandom), CHAR_W'($urandom));
        loaded_codes.delete();
        repeat (count) begin
            code = ($urandom_range(0, 15) == 0) ? CODE_W'($urandom)
                                                : $urandom_range(0, 999999);
            send_item(OPC_ADD, CODE_W'(code), CHAR_W'($urandom));
            loaded_codes.push_back(code);
        end
    endtask

    task automatic send_number(input int unsigned code, input int unsigned year,
                               input int unsigned month, input int unsigned day,
                               input int unsigned seq, input flaw_t flaw);
        logic [CHAR_W-1:0] id [ID_CHARS];
        longint unsigned   digits;
        int unsigned       res;
        int unsigned       chk;
        digits = 64'(code) * 64'd100000000000 + 64'(year) * 64'd10000000
                 + 64'(month) * 64'd100000 + 64'(day) * 64'd1000 + 64'(seq);
        for (int k = ID_CHARS - 2; k >= 0; k--) begin
            id[k]  = CHAR_ZERO + CHAR_W'(digits % 10);
            digits = digits / 10;
        end
        res = 0;
        for (int k = 0; k < ID_CHARS - 1; k++) begin
            res = ((res + (id[k] - CHAR_ZERO)) * 2) % 11;
        end
        chk = (12 - res) % 11;
        if (flaw == FLAW_CHECK) chk = (chk + $urandom_range(1, 10)) % 11;
        id[ID_CHARS-1] = (chk == DIGIT_X) ? CHAR_X : CHAR_ZERO + CHAR_W'(chk);
        if (flaw == FLAW_BYTE) id[$urandom_range(0, ID_CHARS - 1)] = CHAR_W'($urandom);
        if (flaw == FLAW_LOWER_X) id[ID_CHARS-1] = CHAR_LOWER_X;
        for (int k = 0; k < ID_CHARS; k++) begin
            // Table updates and unused opcodes must leave the number intact.
            if (flaw == FLAW_INTERLEAVE && $urandom_range(0, 3) == 0)
                send_item($urandom_range(0, 2) == 0 ? OPC_UNUSED : OPC_ADD,
                          CODE_W'($urandom), CHAR_W'($urandom));
            send_item(OPC_CHAR, CODE_W'($urandom), id[k]);
        end
    endtask

    task automatic play_number();
        int unsigned code, year, month, day, seq, kind, lo, hi, last_day;
        flaw_t       flaw;
        kind = $urandom_range(0, 9);
        lo   = book.year_lo;
        hi   = book.year_hi;
        if (loaded_codes.size() != 0 && $urandom_range(0, 7) != 0)
            code = loaded_codes[$urandom_range(0, loaded_codes.size() - 1)] % 1000000;
        else
            code = $urandom_range(0, 999999);
        if ($urandom_range(0, 3) == 0) begin
            year = leap_probe[$urandom_range(0, 5)];
        end else if (lo <= hi) begin
            year = $urandom_range(lo, hi);
        end else begin
            year = $urandom_range(0, 9999);
        end
        if ($urandom_range(0, 9) == 0) begin
            // Just outside the accepted span, or year zero when the span reaches 9999.
            if ($urandom_range(0, 1) == 0 && lo > 0) year = lo - 1;
            else year = (hi < 9999) ? hi + 1 : 0;
        end
        month = $urandom_range(1, 12);
        if ($urandom_range(0, 11) == 0) begin
            case ($urandom_range(0, 2))
                0: month = 0;
                1: month = 13;
                default: month = $urandom_range(0, 99);
            endcase
        end
        last_day = VerdictBook::month_length(month, year);
        day = $urandom_range(1, last_day);
        case ($urandom_range(0, 9))
            0, 1: day = last_day;
            2: day = last_day + 1;
            3: day = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 99);
            default: begin
            end
        endcase
        seq = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 999);
        case (kind)
            6: flaw = FLAW_CHECK;
            7: flaw = FLAW_BYTE;
            8: flaw = FLAW_INTERLEAVE;
            9: flaw = ($urandom_range(0, 1) == 0) ? FLAW_LOWER_X : FLAW_NONE;
            default: flaw = FLAW_NONE;
        endcase
        if (kind == 9 && flaw == FLAW_NONE) begin
            // Noise burst, then random digits up to the next number boundary.
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(0, 3))
                    0: send_item(OPC_UNUSED, CODE_W'($urandom), CHAR_W'($urandom));
                    1: send_item(OPC_ADD, CODE_W'($urandom), CHAR_W'($urandom));
                    default: send_item(OPC_CHAR, CODE_W'($urandom), CHAR_W'($urandom));
                endcase
            end
            while (book.char_pos != 0)
                send_item(OPC_CHAR, CODE_W'($urandom),
                          CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
        end
        send_number(code, year, month, day, seq, flaw);
    endtask

    initial begin : stimulus
        int unsigned phase;
        int unsigned phase_start;
        int unsigned lo;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening under the reset bounds: widest code, an ignored
        // opcode and a leap-day number.
        send_item(OPC_CLEAR, '1, '1);
        send_item(OPC_ADD, '1, '0);
        send_item(OPC_ADD, CODE_W'(110105), 8'hFF);
        send_item(OPC_UNUSED, CODE_W'(110105), CHAR_ZERO);
        loaded_codes = '{20'hFFFFF, 110105};
        send_number(110105, 1996, 2, 29, 123, FLAW_NONE);

        phase = 0;
        while (items_sent < STIM_ITEMS || book.verdicts < MIN_VERDICTS) begin
            if (phase > 0) begin
                settle();
                if (phase <= 6) begin
                    set_bounds(bound_lo[phase-1], bound_hi[phase-1]);
                end else begin
                    lo = $urandom_range(0, 9999);
                    if ($urandom_range(0, 1) == 0)
                        set_bounds(lo, (lo + $urandom_range(0, 200) > 9999) ? 9999
                                       : lo + $urandom_range(0, 200));
                    else
                        set_bounds(lo, $urandom_range(0, 9999));
                end
            end
            // The second phase overfills the table.
            load_table(phase == 1 ? MAX_REGIONS + 6 : $urandom_range(1, 12));
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                steady = ($urandom_range(0, 4) == 0);
                play_number();
            end
            phase++;
        end

        stop_input();
        while (book.due_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (book.errors == 0) begin
            $display("national_id_number_checker_tb: done, clean");
        end else begin
            $display("national_id_number_checker_tb: done, errors");
        end
        $finish;
    end

endmodule
